>>> rtl/affba_pkg.sv
// Package with constants and types shared by the aligned first-fit block allocator.
`default_nettype none

package affba_pkg;

    // Default number of slots in the occupancy map.
    localparam int MAP_DEPTH_DEF = 128;

    // Widths of the transaction fields.
    localparam int SIZE_W  = 8;
    localparam int INDEX_W = 8;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_CHECK,
        ST_A_RD,
        ST_A_EVAL,
        ST_A_MARK,
        ST_F_WR,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

>>> rtl/affba_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module affba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one read per cycle at the same address; read data is registered and appears the cycle after.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/aligned_first_fit_block_allocator_unit.sv
// Top level of the aligned first-fit block allocator over a slot bitmap in RAM.
//
//   channel | direction | ports                                     | handshake
//   request | in        | s_cmd, s_block_size, s_start_index         | s_valid / s_ready
//   result  | out       | m_ok, m_granted_index                      | m_valid / m_ready
//
// The bitmap lives in a one-bit-wide RAM, one slot per entry; slots are written one per
// cycle and read one at a time. A free writes its N slots free in turn, stopping early
// when clipped at the map end. An allocate checks each candidate against the map end,
// reads its slots in turn (an address state, then an evaluate state), marks a granted
// run slot by slot and loads the result; a candidate is dropped at its first used slot.
// After reset a clearing pass writes every slot free, with s_ready low.
// One request is worked on at a time; a new one is taken while the last result waits.
`default_nettype none

module aligned_first_fit_block_allocator_unit #(
    parameter int MAP_DEPTH = affba_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cmd,
    input  wire logic [affba_pkg::SIZE_W-1:0] s_block_size,
    input  wire logic [affba_pkg::INDEX_W-1:0] s_start_index,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_ok,
    output logic [affba_pkg::INDEX_W-1:0]     m_granted_index
);

    localparam int ADDR_W = $clog2(MAP_DEPTH);
    localparam int SUM_W  = $clog2(MAP_DEPTH + 256);
    localparam int SW     = affba_pkg::SIZE_W;
    localparam int IW     = affba_pkg::INDEX_W;

    affba_pkg::state_t state_reg, state_next;
    logic [SW-1:0]     len_reg, len_next;
    logic [SUM_W-1:0]  cand_reg, cand_next;
    logic [SW-1:0]     k_reg, k_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              pend_ok_reg, pend_ok_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic [IW-1:0]     m_idx_reg, m_idx_next;

    logic [SUM_W-1:0]  slot;
    logic [SUM_W-1:0]  run_end;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_wdata;
    logic              ram_rdata;
    logic              out_free;

    // Bitmap storage.
    affba_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Current slot and end of the candidate run.
    assign slot     = cand_reg + SUM_W'(k_reg);
    assign run_end  = cand_reg + SUM_W'(len_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready         = (state_reg == affba_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_granted_index = m_idx_reg;

    // State and data registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= affba_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        len_reg      <= len_next;
        cand_reg     <= cand_next;
        k_reg        <= k_next;
        pend_ok_reg  <= pend_ok_next;
        pend_idx_reg <= pend_idx_next;
        m_ok_reg     <= m_ok_next;
        m_idx_reg    <= m_idx_next;
    end

    // Sequencer: next state, RAM access and result staging.
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        cand_next     = cand_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        pend_ok_next  = pend_ok_reg;
        pend_idx_next = pend_idx_reg;
        m_valid_next  = m_valid_reg;
        m_ok_next     = m_ok_reg;
        m_idx_next    = m_idx_reg;
        ram_addr      = slot[ADDR_W-1:0];
        ram_we        = 1'b0;
        ram_wdata     = 1'b0;

        // The output register empties when its transaction completes.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            affba_pkg::ST_CLEAR: begin
                ram_addr = clr_reg;
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MAP_DEPTH - 1)) begin
                    state_next = affba_pkg::ST_IDLE;
                end
            end
            affba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    len_next = s_block_size;
                    k_next   = '0;
                    if (s_cmd == affba_pkg::CMD_ALLOC) begin
                        cand_next  = '0;
                        state_next = affba_pkg::ST_A_CHECK;
                    end else begin
                        cand_next  = SUM_W'(s_start_index[IW-1:1]);
                        state_next = affba_pkg::ST_F_WR;
                    end
                end
            end
            affba_pkg::ST_A_CHECK: begin
                // Reject an empty request or a run that spills past the map end.
                if (len_reg == '0 || run_end > SUM_W'(MAP_DEPTH)) begin
                    pend_ok_next  = 1'b0;
                    pend_idx_next = '0;
                    state_next    = affba_pkg::ST_FIN;
                end else begin
                    state_next = affba_pkg::ST_A_RD;
                end
            end
            affba_pkg::ST_A_RD: begin
                state_next = affba_pkg::ST_A_EVAL;
            end
            affba_pkg::ST_A_EVAL: begin
                if (ram_rdata) begin
                    // Slot taken: move on to the next aligned candidate.
                    cand_next  = run_end;
                    k_next     = '0;
                    state_next = affba_pkg::ST_A_CHECK;
                end else if (k_reg == len_reg - 1'b1) begin
                    k_next     = '0;
                    state_next = affba_pkg::ST_A_MARK;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = affba_pkg::ST_A_RD;
                end
            end
            affba_pkg::ST_A_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                k_next    = k_reg + 1'b1;
                if (k_reg == len_reg - 1'b1) begin
                    pend_ok_next  = 1'b1;
                    pend_idx_next = {cand_reg[IW-2:0], 1'b0};
                    state_next    = affba_pkg::ST_FIN;
                end
            end
            affba_pkg::ST_F_WR: begin
                if (k_reg == len_reg || slot >= SUM_W'(MAP_DEPTH)) begin
                    pend_ok_next  = 1'b1;
                    pend_idx_next = '0;
                    state_next    = affba_pkg::ST_FIN;
                end else begin
                    ram_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
            end
            affba_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = pend_ok_reg;
                    m_idx_next   = pend_idx_reg;
                    state_next   = affba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = affba_pkg::ST_IDLE;
            end
        endcase
    end

    // Writes happen only in the clearing, marking and freeing states.
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == affba_pkg::ST_CLEAR || state_reg == affba_pkg::ST_A_MARK ||
                    state_reg == affba_pkg::ST_F_WR))
        else $error("bitmap written outside a write state");

    // Only marking sets a slot used.
    a_mark_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_wdata) |-> (state_reg == affba_pkg::ST_A_MARK))
        else $error("slot set used outside marking");

    // A failed allocation reports index zero.
    a_fail_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> (m_idx_reg == '0))
        else $error("failed allocation with nonzero index");

    // An accepted request leaves the idle state at once.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != affba_pkg::ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // A result is loaded only from the finishing state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == affba_pkg::ST_FIN))
        else $error("result appeared without finishing a request");

endmodule

`default_nettype wire
